/* rtl/core/llcc_pkg.sv */
// shared types, codes and the service point transition function for the connection control
package llcc_pkg;

	localparam int NUM_POINTS = 16;
	localparam int PT_AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
	localparam int CNT_W = $clog2(NUM_POINTS + 1);
	localparam logic [PT_AW-1:0] PT_LAST = PT_AW'(NUM_POINTS - 1);

	// link machine states
	localparam logic [1:0] LK_STANDBY = 2'd0;
	localparam logic [1:0] LK_UCONN   = 2'd1;
	localparam logic [1:0] LK_ACTIVE  = 2'd2;

	// service point states
	localparam logic [2:0] PT_DISC  = 3'd0;
	localparam logic [2:0] PT_CONN  = 3'd1;
	localparam logic [2:0] PT_CPEND = 3'd2;
	localparam logic [2:0] PT_DTR   = 3'd3;
	localparam logic [2:0] PT_SETUP = 3'd4;
	localparam logic [2:0] PT_SPEND = 3'd5;

	// event codes
	localparam logic [4:0] EV_CONREQ  = 5'd0;
	localparam logic [4:0] EV_CONCNF  = 5'd1;
	localparam logic [4:0] EV_CONRSP  = 5'd2;
	localparam logic [4:0] EV_CONIND  = 5'd3;
	localparam logic [4:0] EV_DISIND  = 5'd4;
	localparam logic [4:0] EV_DISREQ  = 5'd5;
	localparam logic [4:0] EV_DATREQ  = 5'd6;
	localparam logic [4:0] EV_UDATREQ = 5'd7;
	localparam logic [4:0] EV_DATIND  = 5'd8;
	localparam logic [4:0] EV_UDATIND = 5'd9;
	localparam logic [4:0] EV_WDOG    = 5'd10;
	localparam logic [4:0] EV_LCONREQ = 5'd11;
	localparam logic [4:0] EV_LCONIND = 5'd12;
	localparam logic [4:0] EV_LCONCNF = 5'd13;
	localparam logic [4:0] EV_LDISIND = 5'd14;
	localparam logic [4:0] EV_LDISREQ = 5'd15;

	// action codes
	localparam logic [4:0] AC_SEND_CMD    = 5'd0;
	localparam logic [4:0] AC_SEND_CNF    = 5'd1;
	localparam logic [4:0] AC_SEND_DISC   = 5'd2;
	localparam logic [4:0] AC_SEND_DATA   = 5'd3;
	localparam logic [4:0] AC_SEND_UDATA  = 5'd4;
	localparam logic [4:0] AC_DELIV_DATA  = 5'd5;
	localparam logic [4:0] AC_DELIV_UDATA = 5'd6;
	localparam logic [4:0] AC_IND_CONN    = 5'd7;
	localparam logic [4:0] AC_IND_CCNF    = 5'd8;
	localparam logic [4:0] AC_IND_DISC    = 5'd9;
	localparam logic [4:0] AC_LINK_CREQ   = 5'd10;
	localparam logic [4:0] AC_LINK_CRSP   = 5'd11;
	localparam logic [4:0] AC_LINK_DREQ   = 5'd12;
	localparam logic [4:0] AC_WD_START    = 5'd13;
	localparam logic [4:0] AC_WD_STOP     = 5'd14;
	localparam logic [4:0] AC_ERROR       = 5'd15;

	// one action word on its way to the output
	typedef struct packed {
		logic       v;
		logic [4:0] act;
		logic [3:0] pt;
	} emit_t;

	// what one point transition does: actions before the link request, the
	// link request itself, and an action after it
	typedef struct packed {
		logic [2:0] nxt;
		logic [1:0] n_pre;
		logic [4:0] act0;
		logic [4:0] act1;
		logic       link_v;
		logic [4:0] link_ev;
		logic       post_v;
		logic [4:0] post;
		logic       keep;
	} pt_fn_t;

	function automatic pt_fn_t point_fn(input logic [2:0] s, input logic [4:0] ev);
		pt_fn_t r;
		r = '0;
		r.nxt = s;
		case (s)
			PT_DISC: begin
				if (ev == EV_CONREQ) begin
					r.nxt = PT_SPEND;
					r.link_v = 1'b1;
					r.link_ev = EV_LCONREQ;
					r.post_v = 1'b1;
					r.post = AC_WD_START;
				end else if (ev == EV_CONIND) begin
					r.nxt = PT_CPEND;
					r.link_v = 1'b1;
					r.link_ev = EV_LCONREQ;
				end
			end
			PT_CONN: begin
				if (ev == EV_CONRSP) begin
					r.n_pre = 2'd2;
					r.act0 = AC_SEND_CNF;
					r.act1 = AC_WD_STOP;
					r.nxt = PT_DTR;
				end
			end
			PT_CPEND: begin
				if (ev == EV_CONRSP || ev == EV_DISREQ) begin
					r.n_pre = 2'd1;
					r.act0 = AC_ERROR;
				end else if (ev == EV_LCONCNF) begin
					r.nxt = PT_CONN;
					r.n_pre = 2'd1;
					r.act0 = AC_IND_CONN;
				end
			end
			PT_DTR: begin
				case (ev)
					EV_CONREQ, EV_CONRSP: begin
						r.n_pre = 2'd1;
						r.act0 = AC_ERROR;
					end
					EV_DISREQ: begin
						r.n_pre = 2'd1;
						r.act0 = AC_SEND_DISC;
						r.nxt = PT_DISC;
						r.link_v = 1'b1;
						r.link_ev = EV_LDISREQ;
					end
					EV_DATREQ: begin
						r.n_pre = 2'd1;
						r.act0 = AC_SEND_DATA;
					end
					EV_UDATREQ: begin
						r.n_pre = 2'd1;
						r.act0 = AC_SEND_UDATA;
					end
					EV_DATIND: begin
						r.n_pre = 2'd1;
						r.act0 = AC_DELIV_DATA;
					end
					EV_UDATIND: begin
						r.n_pre = 2'd1;
						r.act0 = AC_DELIV_UDATA;
					end
					EV_LDISIND: begin
						r.nxt = PT_DISC;
						r.n_pre = 2'd1;
						r.act0 = AC_IND_DISC;
					end
					EV_DISIND: begin
						r.nxt = PT_DISC;
						r.link_v = 1'b1;
						r.link_ev = EV_LDISREQ;
						r.post_v = 1'b1;
						r.post = AC_IND_DISC;
					end
					default: begin
					end
				endcase
			end
			PT_SETUP: begin
				if (ev == EV_CONCNF) begin
					r.nxt = PT_DTR;
					r.n_pre = 2'd2;
					r.act0 = AC_WD_STOP;
					r.act1 = AC_IND_CCNF;
				end else if (ev == EV_DISIND) begin
					r.nxt = PT_DISC;
					r.n_pre = 2'd2;
					r.act0 = AC_WD_STOP;
					r.act1 = AC_IND_DISC;
				end
			end
			PT_SPEND: begin
				if (ev == EV_LCONCNF) begin
					r.n_pre = 2'd1;
					r.act0 = AC_SEND_CMD;
					r.nxt = PT_SETUP;
				end else if (ev == EV_DISIND) begin
					r.n_pre = 2'd1;
					r.act0 = AC_WD_STOP;
					r.nxt = PT_DISC;
				end else if (ev == EV_WDOG) begin
					// link request is raised while the point still counts as bound
					r.nxt = PT_DISC;
					r.link_v = 1'b1;
					r.link_ev = EV_LDISREQ;
					r.keep = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/llcc_state_ram.sv */
// service point state memory with per-entry valid bits and a registered read
module llcc_state_ram (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [llcc_pkg::PT_AW-1:0] waddr,
	input  logic [2:0]                wdata,
	input  logic                      re,
	input  logic [llcc_pkg::PT_AW-1:0] raddr,
	output logic [2:0]                rd_state
);
	import llcc_pkg::*;

	logic [2:0]            mem [NUM_POINTS];
	logic [2:0]            rdata_q;
	logic                  rvalid_q;
	logic [NUM_POINTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we)
				valid_q[waddr] <= 1'b1;
			if (re)
				rvalid_q <= valid_q[raddr];
		end
	end

	// never-written entries read as disconnected
	assign rd_state = rvalid_q ? rdata_q : PT_DISC;

endmodule

/* rtl/core/llcc_result_buf.sv */
// one-deep holding stage that marks the final action word of a step
module llcc_result_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  llcc_pkg::emit_t em,
	input  logic            flush,
	output logic            strobe,
	output logic [4:0]      action,
	output logic [3:0]      target_point,
	output logic            last
);
	import llcc_pkg::*;

	logic       pend_v_q;
	logic [4:0] pend_act_q;
	logic [3:0] pend_pt_q;
	logic       strobe_q;
	logic [4:0] action_q;
	logic [3:0] point_q;
	logic       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= pend_v_q && (em.v || flush);
			if (em.v)
				pend_v_q <= 1'b1;
			else if (flush)
				pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (em.v) begin
			pend_act_q <= em.act;
			pend_pt_q  <= em.pt;
		end
		action_q <= pend_act_q;
		point_q  <= pend_pt_q;
		last_q   <= flush && !em.v;
	end

	assign strobe       = strobe_q;
	assign action       = action_q;
	assign target_point = point_q;
	assign last         = last_q;

endmodule

/* rtl/core/lsap_link_connection_control.sv */
// top level: link and service point connection control sequencer
//
// one event word is taken when start is high and busy is low; busy stays high
// until every action word of that event has been produced. action words leave
// on action/target_point/last, each valid for exactly one cycle while strobe is
// high, and the receiver must take them as they come since there is no way to
// hold them off; last marks the final word of an event, and an event with no
// action gives no word at all. when the link visits every service point, busy
// also covers the walk through the state memory, one point per cycle. each word
// is held in a pending register until the next word or the end of the event
// shows whether it is the last, then passes through an output register, and
// the final word of an event comes out in the first cycle in which busy is low.
// after reset the block is ready at once: per-entry valid bits make the point
// memory read as all disconnected.
module lsap_link_connection_control (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [4:0] mode,
	input  logic [3:0] lsap,
	output logic       strobe,
	output logic [4:0] action,
	output logic [3:0] target_point,
	output logic       last
);
	import llcc_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PT   = 3'd1;
	localparam logic [2:0] S_PT2  = 3'd2;
	localparam logic [2:0] S_LINK = 3'd3;
	localparam logic [2:0] S_FAN  = 3'd4;
	localparam logic [2:0] S_POST = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [1:0]       link_q, link_d;
	logic [CNT_W-1:0] cnt_q;
	logic [4:0]       ev_q;       // point event, then the link request it raised
	logic [4:0]       fev_q;      // event being fanned out
	logic [PT_AW-1:0] pt_q;       // source point, 0 for link input events
	logic [PT_AW-1:0] idx_q;      // fan-out walk position
	pt_fn_t           pf_q;

	logic             accept;
	logic             pt_ok;
	logic [PT_AW-1:0] lsap_addr;

	logic             ram_we, ram_re;
	logic [PT_AW-1:0] ram_waddr, ram_raddr;
	logic [2:0]       rd_state;
	pt_fn_t           f_now;
	logic [4:0]       fn_ev;

	logic             fan;
	logic [4:0]       fan_ev;
	emit_t            lk_em, em;
	logic             flush;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign pt_ok     = (32'(lsap) < NUM_POINTS);
	assign lsap_addr = PT_AW'(lsap);

	// point transition shared by the addressed point and the fan-out walk
	assign fn_ev = (state_q == S_FAN) ? fev_q : ev_q;
	assign f_now = point_fn(rd_state, fn_ev);

	assign ram_we    = (state_q == S_PT) || (state_q == S_FAN);
	assign ram_waddr = (state_q == S_FAN) ? idx_q : pt_q;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				ram_re    = accept && (mode <= EV_WDOG) && pt_ok;
				ram_raddr = lsap_addr;
			end
			S_LINK: begin
				ram_re    = fan;
				ram_raddr = '0;
			end
			S_FAN: begin
				ram_re    = (idx_q != PT_LAST);
				ram_raddr = idx_q + PT_AW'(1);
			end
			default: begin
			end
		endcase
	end

	llcc_state_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (ram_we),
		.waddr    (ram_waddr),
		.wdata    (f_now.nxt),
		.re       (ram_re),
		.raddr    (ram_raddr),
		.rd_state (rd_state)
	);

	// link machine step, resolved in the link state of the sequencer
	always_comb begin
		link_d = link_q;
		lk_em  = '0;
		fan    = 1'b0;
		fan_ev = EV_LCONCNF;
		lk_em.pt = 4'(pt_q);
		case (link_q)
			LK_STANDBY: begin
				if (ev_q == EV_LCONIND) begin
					link_d     = LK_ACTIVE;
					lk_em.v    = 1'b1;
					lk_em.act  = AC_LINK_CRSP;
				end else if (ev_q == EV_LCONREQ) begin
					link_d     = LK_UCONN;
					lk_em.v    = 1'b1;
					lk_em.act  = AC_LINK_CREQ;
				end
			end
			LK_UCONN: begin
				if (ev_q == EV_LCONCNF) begin
					link_d = LK_ACTIVE;
					fan    = 1'b1;
				end else if (ev_q == EV_LDISIND) begin
					link_d = LK_STANDBY;
					fan    = 1'b1;
					fan_ev = EV_LDISIND;
				end else if (ev_q == EV_LDISREQ) begin
					link_d = LK_STANDBY;
				end
			end
			LK_ACTIVE: begin
				if (ev_q == EV_LCONREQ) begin
					fan = 1'b1;
				end else if (ev_q == EV_LDISREQ) begin
					// drop the link only when no point is bound any more
					if (cnt_q == '0 && !pf_q.keep) begin
						link_d    = LK_STANDBY;
						lk_em.v   = 1'b1;
						lk_em.act = AC_LINK_DREQ;
					end
				end else if (ev_q == EV_LDISIND) begin
					link_d = LK_STANDBY;
					fan    = 1'b1;
					fan_ev = EV_LDISIND;
				end
			end
			default: begin
			end
		endcase
	end

	// action word source for this cycle
	always_comb begin
		em    = '0;
		flush = 1'b0;
		case (state_q)
			S_PT: begin
				em.v   = (f_now.n_pre != 2'd0);
				em.act = f_now.act0;
				em.pt  = 4'(pt_q);
			end
			S_PT2: begin
				em.v   = (pf_q.n_pre == 2'd2);
				em.act = pf_q.act1;
				em.pt  = 4'(pt_q);
			end
			S_LINK: begin
				if (state_q == S_LINK)
					em = lk_em;
			end
			S_FAN: begin
				em.v   = (f_now.n_pre != 2'd0);
				em.act = f_now.act0;
				em.pt  = 4'(idx_q);
			end
			S_POST: begin
				em.v   = pf_q.post_v;
				em.act = pf_q.post;
				em.pt  = 4'(pt_q);
			end
			S_FIN: begin
				flush = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode <= EV_WDOG)
						state_d = pt_ok ? S_PT : S_FIN;
					else if (mode <= EV_LDISREQ)
						state_d = S_LINK;
					else
						state_d = S_FIN;
				end
			end
			S_PT:   state_d = S_PT2;
			S_PT2:  state_d = pf_q.link_v ? S_LINK : S_POST;
			S_LINK: state_d = fan ? S_FAN : S_POST;
			S_FAN:  state_d = (idx_q == PT_LAST) ? S_POST : S_FAN;
			S_POST: state_d = S_FIN;
			S_FIN:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			link_q  <= LK_STANDBY;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_LINK)
				link_q <= link_d;
			// bound count follows entries into and out of disconnected
			if (ram_we) begin
				if (rd_state == PT_DISC && f_now.nxt != PT_DISC)
					cnt_q <= cnt_q + CNT_W'(1);
				else if (rd_state != PT_DISC && f_now.nxt == PT_DISC)
					cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ev_q <= mode;
					pt_q <= (mode <= EV_WDOG) ? lsap_addr : '0;
					pf_q <= '0;
				end
			end
			S_PT: begin
				pf_q <= f_now;
				ev_q <= f_now.link_ev;
			end
			S_LINK: begin
				fev_q <= fan_ev;
				idx_q <= '0;
			end
			S_FAN: begin
				if (idx_q != PT_LAST)
					idx_q <= idx_q + PT_AW'(1);
			end
			default: begin
			end
		endcase
	end

	llcc_result_buf u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.em           (em),
		.flush        (flush),
		.strobe       (strobe),
		.action       (action),
		.target_point (target_point),
		.last         (last)
	);

endmodule
